### src/f2t_pkg.sv
// package: format codes and a helper function for the float32 encoder
package f2t_pkg;

  localparam logic [4:0] FMT_F32      = 5'd0;
  localparam logic [4:0] FMT_F64      = 5'd1;
  localparam logic [4:0] FMT_I32      = 5'd2;
  localparam logic [4:0] FMT_I64      = 5'd3;
  localparam logic [4:0] FMT_BOOL     = 5'd4;
  localparam logic [4:0] FMT_F16      = 5'd5;
  localparam logic [4:0] FMT_BF16     = 5'd6;
  localparam logic [4:0] FMT_I8       = 5'd7;
  localparam logic [4:0] FMT_U8       = 5'd8;
  localparam logic [4:0] FMT_I16      = 5'd9;
  localparam logic [4:0] FMT_U16      = 5'd10;
  localparam logic [4:0] FMT_U32      = 5'd11;
  localparam logic [4:0] FMT_U64      = 5'd12;
  localparam logic [4:0] FMT_E4M3     = 5'd13;
  localparam logic [4:0] FMT_E5M2     = 5'd14;
  localparam logic [4:0] FMT_E4M3FNUZ = 5'd15;
  localparam logic [4:0] FMT_E5M2FNUZ = 5'd16;

  // 1e-9f as a bit pattern
  localparam logic [31:0] BOOL_EPS = 32'h3089705F;

  // truncating cast with saturation, width selected by nbits (8..64)
  function automatic logic [63:0] to_int(input logic [31:0] x, input logic [6:0] nbits,
                                         input logic is_signed);
    logic [7:0]  e;
    logic [63:0] mask, pos_max, neg_lim, mag, full;
    logic        huge;
    logic [7:0]  ex;
    e       = x[30:23];
    mask    = (nbits == 7'd64) ? '1 : ((64'd1 << nbits[5:0]) - 64'd1);
    pos_max = is_signed ? (mask >> 1) : mask;
    neg_lim = is_signed ? (pos_max + 64'd1) : 64'd0;
    full    = {40'd0, 1'b1, x[22:0]};
    huge    = 1'b0;
    mag     = '0;
    ex      = e - 8'd127;
    if (e == 8'hFF) begin
      huge = 1'b1;
    end else if (e >= 8'd191) begin
      huge = 1'b1;
    end else if (e >= 8'd150) begin
      mag = full << ex[5:0] - 6'd23;
    end else if (e >= 8'd127) begin
      mag = full >> (6'd23 - ex[5:0]);
    end
    if (e == 8'hFF && x[22:0] != 23'd0) begin
      to_int = '0;
    end else if (e < 8'd127) begin
      to_int = '0;
    end else if (!x[31]) begin
      to_int = (huge || mag > pos_max) ? pos_max : mag;
    end else begin
      if (huge || mag > neg_lim) mag = neg_lim;
      to_int = (64'd0 - mag) & mask;
    end
  endfunction

endpackage

### src/float32_to_tensor_dtype_encoder.sv
// top level: float32 to tensor element format encoder
// the result is registered and valid in the cycle after the input transfer
// throughput: one transfer per cycle, limited only by the result register
// the output register is refilled in the cycle it is taken
// reset: asynchronous, active low; clears result valid and sets format to f32
module float32_to_tensor_dtype_encoder #(
  parameter int INDEX_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [4:0]              cfg_wdata_i,    // element_format
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [32+INDEX_BITS-1:0] s_axis_tdata,  // value_bits, element_index
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [64+INDEX_BITS-1:0] m_axis_tdata   // encoded_bits, out_index
);
  import f2t_pkg::*;

  logic [4:0]            fmt_q;
  logic                  vld_q;
  logic [63:0]           enc_q, enc_d;
  logic [INDEX_BITS-1:0] idx_q;
  logic [31:0]           x;
  logic [7:0]            e;
  logic [8:0]            ex;
  logic                  zero_mag;
  logic [6:0]            nbits;
  logic                  sgn;
  logic [63:0]           ival;
  logic [4:0]            lz;

  assign x = s_axis_tdata[31:0];
  assign e = x[30:23];
  assign zero_mag = (x[30:0] == 31'd0);
  assign s_axis_tready = !vld_q || m_axis_tready;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {idx_q, enc_q};

  // integer width select
  always_comb begin
    nbits = 7'd64;
    sgn   = 1'b1;
    case (fmt_q)
      FMT_I32: begin nbits = 7'd32; sgn = 1'b1; end
      FMT_I8:  begin nbits = 7'd8;  sgn = 1'b1; end
      FMT_U8:  begin nbits = 7'd8;  sgn = 1'b0; end
      FMT_I16: begin nbits = 7'd16; sgn = 1'b1; end
      FMT_U16: begin nbits = 7'd16; sgn = 1'b0; end
      FMT_U32: begin nbits = 7'd32; sgn = 1'b0; end
      FMT_U64: begin nbits = 7'd64; sgn = 1'b0; end
      default: begin nbits = 7'd64; sgn = 1'b1; end
    endcase
  end
  assign ival = to_int(x, nbits, sgn);

  // leading one position of a subnormal mantissa
  always_comb begin
    lz = '0;
    for (int i = 0; i < 23; i++) begin
      if (x[i]) lz = 5'(i);
    end
  end

  // conversion
  always_comb begin
    enc_d = {32'd0, x};
    ex    = '0;
    case (fmt_q)
      FMT_F64: begin
        if (e == 8'hFF) begin
          enc_d = {x[31], 11'h7FF, x[22] | (x[22:0] != 23'd0), x[21:0], 29'd0};
        end else if (e == 8'd0) begin
          if (x[22:0] == 23'd0) enc_d = {x[31], 63'd0};
          else enc_d = {x[31], 11'(lz) + 11'd874,
                        52'(({29'd0, x[22:0]} << (6'd52 - 6'(lz))))};
        end else begin
          enc_d = {x[31], 11'(e) + 11'd896, x[22:0], 29'd0};
        end
      end
      FMT_I32, FMT_I64, FMT_I8, FMT_U8, FMT_I16, FMT_U16, FMT_U32, FMT_U64:
        enc_d = ival;
      FMT_BOOL:
        enc_d = {63'd0, ({1'b0, x[30:0]} > BOOL_EPS) && ({1'b0, x[30:0]} <= 32'h7F800000)};
      FMT_F16: begin
        ex = {1'b0, e} - 9'd112;
        if (e <= 8'd112)      enc_d = {48'd0, x[31], 15'd0};
        else if (e >= 8'd143) enc_d = {48'd0, x[31], 15'h7C00};
        else                  enc_d = {48'd0, x[31], ex[4:0], x[22:13]};
      end
      FMT_BF16: enc_d = {48'd0, x[31:16]};
      FMT_E4M3: begin
        ex = {1'b0, e} - 9'd120;
        if (e <= 8'd120)      enc_d = {56'd0, x[31], 7'd0};
        else if (e >= 8'd135) enc_d = {56'd0, x[31], 7'h7E};
        else                  enc_d = {56'd0, x[31], ex[3:0], x[22:20]};
      end
      FMT_E5M2: begin
        ex = {1'b0, e} - 9'd112;
        if (e <= 8'd112)      enc_d = {56'd0, x[31], 7'd0};
        else if (e >= 8'd143) enc_d = {56'd0, x[31], 7'h7C};
        else                  enc_d = {56'd0, x[31], ex[4:0], x[22:21]};
      end
      FMT_E4M3FNUZ: begin
        ex = {1'b0, e} - 9'd119;
        if (e == 8'hFF || zero_mag || e <= 8'd119) enc_d = '0;
        else if (e >= 8'd135) enc_d = {56'd0, x[31], 7'h7F};
        else                  enc_d = {56'd0, x[31], ex[3:0], x[22:20]};
      end
      FMT_E5M2FNUZ: begin
        ex = {1'b0, e} - 9'd111;
        if (e == 8'hFF || zero_mag || e <= 8'd111) enc_d = '0;
        else if (e >= 8'd143) enc_d = {56'd0, x[31], 7'h7F};
        else                  enc_d = {56'd0, x[31], ex[4:0], x[22:21]};
      end
      default: enc_d = {32'd0, x};
    endcase
  end

  // format register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_F32;
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (s_axis_tready) vld_q <= s_axis_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      enc_q <= enc_d;
      idx_q <= s_axis_tdata[32+INDEX_BITS-1:32];
    end
  end

endmodule

### test/f2t_checker.sv
// checker: watches both streams, predicts each encoded element and compares
module f2t_checker
  import f2t_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value_bits, element_index
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // encoded_bits, out_index
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] bits;
    logic [15:0] idx;
  } element_t;

  logic [4:0] fmt_shadow;
  element_t   expected_q[$];

  // truncating saturating cast to an integer of nbits
  function automatic logic [63:0] cast_int(logic [31:0] x, int nbits, bit sgn);
    logic [63:0] lim_mask, hi, lo_mag, mag;
    logic [23:0] full;
    int          ex;
    bit          huge;
    lim_mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    hi       = sgn ? (lim_mask >> 1) : lim_mask;
    lo_mag   = sgn ? hi + 64'd1 : 64'd0;
    full     = {1'b1, x[22:0]};
    huge     = 0;
    mag      = 0;
    if (x[30:23] == 8'hFF) begin
      if (x[22:0] != 0) return 64'd0;
      huge = 1;
    end else begin
      ex = int'(x[30:23]) - 127;
      if (ex < 0) return 64'd0;
      if (ex >= 64) huge = 1;
      else if (ex >= 23) mag = 64'(full) << (ex - 23);
      else mag = 64'(full) >> (23 - ex);
    end
    if (!x[31]) return (huge || mag > hi) ? hi : mag;
    if (huge || mag > lo_mag) mag = lo_mag;
    return (64'd0 - mag) & lim_mask;
  endfunction

  // exact widening to double
  function automatic logic [63:0] widen_f64(logic [31:0] x);
    logic [22:0] m;
    int          p;
    m = x[22:0];
    if (x[30:23] == 8'hFF) begin
      if (m != 0) m[22] = 1'b1;
      return {x[31], 11'h7FF, m, 29'd0};
    end
    if (x[30:23] == 0) begin
      if (m == 0) return {x[31], 63'd0};
      p = 0;
      for (int i = 0; i < 23; i++) if (m[i]) p = i;
      return {x[31], 11'(p + 874), 52'((64'(m) << (52 - p)))};
    end
    return {x[31], 11'(int'(x[30:23]) + 896), m, 29'd0};
  endfunction

  // truncating narrow float, ieee-like overflow code
  function automatic logic [63:0] narrow(logic [31:0] x, int bias, int mb, int emax,
                                         logic [15:0] ovf, int sb);
    logic [63:0] s;
    int          ex;
    s  = 64'(x[31]) << sb;
    ex = int'(x[30:23]) - 127 + bias;
    if (ex <= 0) return s;
    if (ex >= emax) return s | 64'(ovf);
    return s | (64'(ex) << mb) | 64'((x >> (23 - mb)) & ((32'd1 << mb) - 1));
  endfunction

  // fnuz variants: nan, inf and zero all map to 0
  function automatic logic [63:0] narrow_fnuz(logic [31:0] x, int bias, int mb, int emax);
    int ex;
    if (x[30:23] == 8'hFF || x[30:0] == 0) return 64'd0;
    ex = int'(x[30:23]) - 127 + bias;
    if (ex <= 0) return 64'd0;
    if (ex >= emax) return {56'd0, x[31], 7'h7F};
    return {56'd0, x[31], 7'd0} | (64'(ex) << mb)
         | 64'((x >> (23 - mb)) & ((32'd1 << mb) - 1));
  endfunction

  function automatic logic [63:0] encode_element(logic [4:0] f, logic [31:0] x);
    case (f)
      FMT_F64:      return widen_f64(x);
      FMT_I32:      return cast_int(x, 32, 1);
      FMT_I64:      return cast_int(x, 64, 1);
      FMT_BOOL:     return (x[30:0] > BOOL_EPS[30:0] && x[30:0] <= 31'h7F800000) ?
                           64'd1 : 64'd0;
      FMT_F16:      return narrow(x, 15, 10, 31, 16'h7C00, 15);
      FMT_BF16:     return 64'(x[31:16]);
      FMT_I8:       return cast_int(x, 8, 1);
      FMT_U8:       return cast_int(x, 8, 0);
      FMT_I16:      return cast_int(x, 16, 1);
      FMT_U16:      return cast_int(x, 16, 0);
      FMT_U32:      return cast_int(x, 32, 0);
      FMT_U64:      return cast_int(x, 64, 0);
      FMT_E4M3:     return narrow(x, 7, 3, 15, 16'h7E, 7);
      FMT_E5M2:     return narrow(x, 15, 2, 31, 16'h7C, 7);
      FMT_E4M3FNUZ: return narrow_fnuz(x, 8, 3, 16);
      FMT_E5M2FNUZ: return narrow_fnuz(x, 16, 2, 32);
      default:      return 64'(x);
    endcase
  endfunction

  // track format writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    element_t e, got;
    if (!rst_ni) begin
      fmt_shadow = FMT_F32;
      fail_count = 0;
      expected_q.delete();
      pending    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        // result bus carries encoded_bits low and out_index high
        got.bits = m_axis_tdata[63:0];
        got.idx  = m_axis_tdata[79:64];
        if (expected_q.size() == 0) begin
          $error("unexpected transfer %h", got);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (got.bits !== e.bits) begin
            $error("encoded_bits: expected %h, got %h", e.bits, got.bits);
            fail_count++;
          end
          if (got.idx !== e.idx) begin
            $error("out_index: expected %h, got %h", e.idx, got.idx);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back({encode_element(fmt_shadow, s_axis_tdata[31:0]),
                              s_axis_tdata[47:32]});
      if (cfg_we_i) fmt_shadow = cfg_wdata_i;
      pending = expected_q.size();
    end
  end
endmodule

### test/tb.sv
// testbench top: stimulus, format sweep and verdict for the float32 encoder
module tb;
  import f2t_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [4:0]  cfg_wdata_i = FMT_F32;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  int          fail_count, pending;
  int          cycles = 0;
  bit          hold_off = 0;

  float32_to_tensor_dtype_encoder #(.INDEX_BITS(16)) DUT (.*);
  f2t_checker u_checker (.*);

  initial forever #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls on its own pattern, or holds off entirely
  always @(negedge clk_i) begin
    int mode;
    mode = (cycles / 300) % 3;
    if (hold_off) m_axis_tready <= 0;
    else if (mode == 0) m_axis_tready <= 1;
    else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 1) == 0);
  end

  // random float pattern biased toward interesting exponents
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'($urandom_range(100, 150));
      1: v[30:23] = 8'($urandom_range(120, 200));
      2: v[30:23] = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      3: v[30:23] = 8'($urandom_range(85, 145));
      default: ;
    endcase
    return v;
  endfunction

  // one transfer: hold until accepted
  task automatic send_element(logic [31:0] v);
    s_axis_tdata  <= {16'($urandom), v};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_format(logic [4:0] f);
    cfg_wdata_i <= f;
    cfg_we_i    <= 1;
    @(negedge clk_i);
    cfg_we_i    <= 0;
  endtask

  logic [31:0] directed[$] = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000,
    32'h7FC00001, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF, 32'h3F800000,
    32'hBF800000, 32'h3089705F, 32'h30897060, 32'h4F000000, 32'hCF000000,
    32'h5F000000, 32'hDF000000, 32'h477FE000, 32'h43800000, 32'hC3000000,
    32'h3A800000, 32'h7F7FFFFF, 32'h387FFFFF, 32'h3C000000};

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    for (int f = 0; f <= 17; f++) begin
      if (f != 0) write_format((f == 17) ? 5'd31 : 5'(f));
      // directed corners, back to back
      foreach (directed[i]) send_element(directed[i]);
      // random bursts
      for (int n = 0; n < 7; n++) begin
        if ($urandom_range(0, 3) == 0) idle_gap();
        send_element(pick_value());
      end
      if (f == 5) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
          begin
            repeat (60) @(negedge clk_i);
            hold_off = 0;
          end
          for (int n = 0; n < 20; n++) send_element(pick_value());
        join
      end
      drain();
    end
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### float32_to_tensor_dtype_encoder.f
src/f2t_pkg.sv
src/float32_to_tensor_dtype_encoder.sv
test/f2t_checker.sv
test/tb.sv
